>>> hw/rtl/tlca_pkg.sv
// Package for the binary-lifting lowest common ancestor unit.
// Holds sizes, table entry type, action and state codes. No dependencies.
package tlca_pkg;

  localparam int MAX_NODES  = 1024;
  localparam int LEVELS     = 10;
  localparam int NODE_W     = $clog2(MAX_NODES);
  localparam int LEVEL_W    = $clog2(LEVELS);
  localparam int COUNT_W    = 11;
  localparam int DEPTH_W    = LEVELS;
  localparam int ANC_ADDR_W = LEVEL_W + NODE_W;
  localparam int ANC_DEPTH  = LEVELS * MAX_NODES;

  localparam logic [NODE_W-1:0] NO_ANCESTOR = '1;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_SET   = 2'd1,
    ACT_BUILD = 2'd2,
    ACT_QUERY = 2'd3
  } action_t;

  typedef struct packed {
    logic              valid;
    logic [NODE_W-1:0] index;
  } anc_entry_t;

  typedef enum logic [11:0] {
    ST_IDLE   = 12'b000000000001,
    ST_CLEAR  = 12'b000000000010,
    ST_BLD_RD = 12'b000000000100,
    ST_BLD_UP = 12'b000000001000,
    ST_DEP_RD = 12'b000000010000,
    ST_DEP_WR = 12'b000000100000,
    ST_Q_DEP  = 12'b000001000000,
    ST_Q_LIFT = 12'b000010000000,
    ST_Q_JRD  = 12'b000100000000,
    ST_Q_JMP  = 12'b001000000000,
    ST_Q_FIN  = 12'b010000000000,
    ST_OUT    = 12'b100000000000
  } state_t;

endpackage

>>> hw/rtl/tree_lowest_common_ancestor_unit.sv
// Binary-lifting lowest common ancestor unit; depends on tlca_pkg.
// A query result is held back while an earlier result is still stalled.
// One item at a time, in_stall high while busy; the one registered read a cycle sets all.
// Reset (synchronous, rst_n low) clears control state and node_count to 1; tables undefined.
module tree_lowest_common_ancestor_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [tlca_pkg::COUNT_W-1:0] cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_action,
  input  logic [tlca_pkg::NODE_W-1:0] in_first_node,
  input  logic [tlca_pkg::NODE_W-1:0] in_second_node,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [tlca_pkg::NODE_W-1:0] out_ancestor
);

  localparam int NW = tlca_pkg::NODE_W;
  localparam int LW = tlca_pkg::LEVEL_W;
  localparam int DW = tlca_pkg::DEPTH_W;
  localparam int AW = tlca_pkg::ANC_ADDR_W;

  // tables
  tlca_pkg::anc_entry_t anc_mem [tlca_pkg::ANC_DEPTH];
  logic [DW-1:0]        dep_mem [tlca_pkg::MAX_NODES];

  tlca_pkg::state_t state_r, state_nxt;
  logic [tlca_pkg::COUNT_W-1:0] count_r;
  logic [NW-1:0] u_r, v_r, j_r, res_r;
  logic [LW-1:0] k_r;
  logic [DW-1:0] d_r, diff_r, du_r;
  logic          phase_r;     // second of two reads in a step
  logic          same_r;
  logic          out_valid_r;

  // memory port signals
  logic       anc_we, anc_re;
  logic [AW-1:0] anc_waddr, anc_raddr;
  tlca_pkg::anc_entry_t anc_wdata, anc_rdata_r;
  logic       dep_we;
  logic [NW-1:0] dep_waddr, dep_raddr;
  logic [DW-1:0] dep_wdata, dep_rdata_r;
  tlca_pkg::anc_entry_t eu_r;

  function automatic logic [AW-1:0] addr_of(input logic [LW-1:0] k, input logic [NW-1:0] n);
    addr_of = AW'(k) * AW'(tlca_pkg::MAX_NODES) + AW'(n);
  endfunction

  always_ff @(posedge clk) begin
    if (anc_we) anc_mem[anc_waddr] <= anc_wdata;
    if (anc_re) anc_rdata_r <= anc_mem[anc_raddr];
    if (dep_we) dep_mem[dep_waddr] <= dep_wdata;
    dep_rdata_r <= dep_mem[dep_raddr];
  end

  logic [tlca_pkg::COUNT_W-1:0] n_eff;
  always_comb begin
    n_eff = count_r;
    if (count_r == '0) n_eff = tlca_pkg::COUNT_W'(1);
    if (count_r > tlca_pkg::COUNT_W'(tlca_pkg::MAX_NODES))
      n_eff = tlca_pkg::COUNT_W'(tlca_pkg::MAX_NODES);
  end

  logic a_ok, b_ok, accept;
  assign a_ok   = tlca_pkg::COUNT_W'(in_first_node) < n_eff;
  assign b_ok   = tlca_pkg::COUNT_W'(in_second_node) < n_eff;
  assign in_stall = (state_r != tlca_pkg::ST_IDLE);
  assign accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_ancestor = res_r;

  logic j_last, k_last;
  assign j_last = (j_r == NW'(tlca_pkg::MAX_NODES - 1));
  assign k_last = (k_r == LW'(tlca_pkg::LEVELS - 1));

  // datapath control, one memory read per cycle
  always_comb begin
    state_nxt = state_r;
    anc_we = 1'b0; anc_waddr = '0; anc_wdata = '0;
    anc_re = 1'b0; anc_raddr = '0;
    dep_we = 1'b0; dep_waddr = '0; dep_wdata = '0;
    dep_raddr = u_r;
    unique case (state_r)
      tlca_pkg::ST_IDLE: begin
        dep_raddr = in_first_node;
        if (accept) begin
          unique case (tlca_pkg::action_t'(in_action))
            tlca_pkg::ACT_CLEAR: state_nxt = tlca_pkg::ST_CLEAR;
            tlca_pkg::ACT_SET: begin
              if (a_ok && b_ok) begin
                anc_we    = 1'b1;
                anc_waddr = addr_of('0, in_first_node);
                anc_wdata = '{valid: 1'b1, index: in_second_node};
              end
            end
            tlca_pkg::ACT_BUILD:
              state_nxt = (tlca_pkg::LEVELS > 1) ? tlca_pkg::ST_BLD_RD : tlca_pkg::ST_DEP_RD;
            tlca_pkg::ACT_QUERY: if (a_ok && b_ok) state_nxt = tlca_pkg::ST_Q_DEP;
            default: ;
          endcase
        end
      end
      tlca_pkg::ST_CLEAR: begin
        anc_we = 1'b1; anc_waddr = addr_of(k_r, j_r); anc_wdata = '0;
        dep_we = (k_r == '0); dep_waddr = j_r; dep_wdata = '0;
        if (j_last && k_last) state_nxt = tlca_pkg::ST_IDLE;
      end
      // build: read level k-1 of j, then level k-1 of its parent, write level k
      tlca_pkg::ST_BLD_RD: begin
        anc_re = 1'b1;
        anc_raddr = phase_r ? addr_of(k_r - LW'(1), anc_rdata_r.index)
                            : addr_of(k_r - LW'(1), j_r);
        if (phase_r) state_nxt = tlca_pkg::ST_BLD_UP;
      end
      tlca_pkg::ST_BLD_UP: begin
        anc_we = 1'b1; anc_waddr = addr_of(k_r, j_r);
        anc_wdata = (eu_r.valid && anc_rdata_r.valid) ?
                    tlca_pkg::anc_entry_t'{valid: 1'b1, index: anc_rdata_r.index} : '0;
        if (j_last && k_last) state_nxt = tlca_pkg::ST_DEP_RD;
        else state_nxt = tlca_pkg::ST_BLD_RD;
      end
      // depth: walk levels from top for node j
      tlca_pkg::ST_DEP_RD: begin
        anc_re = 1'b1; anc_raddr = addr_of(k_r, u_r);
        state_nxt = tlca_pkg::ST_DEP_WR;
      end
      tlca_pkg::ST_DEP_WR: begin
        if (k_r == '0) begin
          dep_we = 1'b1; dep_waddr = j_r;
          dep_wdata = anc_rdata_r.valid ? (d_r | DW'(1)) : d_r;
          state_nxt = j_last ? tlca_pkg::ST_IDLE : tlca_pkg::ST_DEP_RD;
        end else state_nxt = tlca_pkg::ST_DEP_RD;
      end
      // query: read the depths of both nodes, then compare
      tlca_pkg::ST_Q_DEP: begin
        dep_raddr = v_r;
        if (phase_r) state_nxt = tlca_pkg::ST_Q_LIFT;
      end
      tlca_pkg::ST_Q_LIFT: begin
        anc_raddr = addr_of(k_r, v_r);
        anc_re = 1'b1;
        if (phase_r && k_r == '0) state_nxt = tlca_pkg::ST_Q_JRD;
      end
      tlca_pkg::ST_Q_JRD: begin
        anc_re = 1'b1;
        anc_raddr = phase_r ? addr_of(k_r, v_r) : addr_of(k_r, u_r);
        if (phase_r) state_nxt = tlca_pkg::ST_Q_JMP;
      end
      tlca_pkg::ST_Q_JMP: begin
        if (k_r == '0) state_nxt = tlca_pkg::ST_Q_FIN;
        else state_nxt = tlca_pkg::ST_Q_JRD;
      end
      tlca_pkg::ST_Q_FIN: begin
        anc_re = !phase_r; anc_raddr = addr_of('0, u_r);
        if (phase_r) state_nxt = tlca_pkg::ST_OUT;
      end
      tlca_pkg::ST_OUT: if (!out_valid_r || !out_stall) state_nxt = tlca_pkg::ST_IDLE;
      default: state_nxt = tlca_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tlca_pkg::ST_IDLE;
      count_r <= tlca_pkg::COUNT_W'(1);
      out_valid_r <= 1'b0;
      phase_r <= 1'b0;
      k_r <= '0; j_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) count_r <= cfg_wr_data;
      if (state_r == tlca_pkg::ST_OUT && (!out_valid_r || !out_stall)) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      unique case (state_r)
        tlca_pkg::ST_IDLE: begin
          phase_r <= 1'b0; j_r <= '0;
          v_r <= in_second_node;
          if (accept && tlca_pkg::action_t'(in_action) == tlca_pkg::ACT_BUILD) begin
            k_r <= (tlca_pkg::LEVELS > 1) ? LW'(1) : LW'(tlca_pkg::LEVELS - 1);
            u_r <= '0; d_r <= '0;
          end else begin
            k_r <= '0;
            u_r <= in_first_node;
          end
        end
        tlca_pkg::ST_CLEAR: begin
          j_r <= j_r + NW'(1);
          if (j_last) k_r <= k_r + LW'(1);
        end
        tlca_pkg::ST_BLD_RD: begin
          // hold the parent entry; a missing parent still reads node 0 harmlessly
          if (phase_r) eu_r <= anc_rdata_r;
          phase_r <= !phase_r;
        end
        tlca_pkg::ST_BLD_UP: begin
          j_r <= j_r + NW'(1);
          if (j_last) begin
            k_r <= k_last ? LW'(tlca_pkg::LEVELS - 1) : k_r + LW'(1);
            if (k_last) begin u_r <= '0; d_r <= '0; end
          end
        end
        tlca_pkg::ST_DEP_WR: begin
          if (k_r == '0) begin
            k_r <= LW'(tlca_pkg::LEVELS - 1);
            j_r <= j_r + NW'(1);
            u_r <= j_r + NW'(1);
            d_r <= '0;
          end else begin
            if (anc_rdata_r.valid) begin
              d_r <= d_r | (DW'(1) << k_r);
              u_r <= anc_rdata_r.index;
            end
            k_r <= k_r - LW'(1);
          end
        end
        tlca_pkg::ST_Q_DEP: begin
          phase_r <= !phase_r;
          if (!phase_r) du_r <= dep_rdata_r;
          else begin
            // keep u as the shallower node
            if (du_r > dep_rdata_r) begin
              u_r <= v_r; v_r <= u_r; diff_r <= du_r - dep_rdata_r;
            end else diff_r <= dep_rdata_r - du_r;
            k_r <= LW'(tlca_pkg::LEVELS - 1);
          end
        end
        tlca_pkg::ST_Q_LIFT: begin
          phase_r <= !phase_r;
          if (phase_r) begin
            if (diff_r[k_r] && anc_rdata_r.valid) v_r <= anc_rdata_r.index;
            if (k_r == '0) k_r <= LW'(tlca_pkg::LEVELS - 1);
            else k_r <= k_r - LW'(1);
          end
        end
        tlca_pkg::ST_Q_JRD: begin
          phase_r <= !phase_r;
          if (phase_r) eu_r <= anc_rdata_r;
          // equal right after lifting: that node is the answer
          else if (k_last) same_r <= (u_r == v_r);
        end
        tlca_pkg::ST_Q_JMP: begin
          if (u_r != v_r && eu_r.valid && eu_r != anc_rdata_r) begin
            u_r <= eu_r.index; v_r <= anc_rdata_r.index;
          end
          if (k_r != '0) k_r <= k_r - LW'(1);
        end
        tlca_pkg::ST_Q_FIN: phase_r <= !phase_r;
        tlca_pkg::ST_OUT: begin
          // hold the result until the slot is free
          if (!out_valid_r || !out_stall) begin
            if (same_r) res_r <= u_r;
            else res_r <= anc_rdata_r.valid ? anc_rdata_r.index : tlca_pkg::NO_ANCESTOR;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

>>> bench/tb_tree_lowest_common_ancestor_unit.sv
// Testbench for tree_lowest_common_ancestor_unit: directed table, then random tree sessions.
// Holds its own binary-lifting predictor and a queue of expected ancestors. Depends on tlca_pkg.
`timescale 1ns / 100ps
module tb_tree_lowest_common_ancestor_unit;

  localparam int WATCHDOG_LIMIT = 400000;
  localparam int COUNT_W   = tlca_pkg::COUNT_W;
  localparam int NODE_W    = tlca_pkg::NODE_W;
  localparam int LEVELS    = tlca_pkg::LEVELS;
  localparam int MAX_NODES = tlca_pkg::MAX_NODES;

  logic                clk;
  logic                rst_n;
  logic                cfg_wr_en;
  logic [COUNT_W-1:0]  cfg_wr_data;
  logic                in_valid;
  logic                in_stall;
  logic [1:0]          in_action;
  logic [NODE_W-1:0]   in_first_node;
  logic [NODE_W-1:0]   in_second_node;
  logic                out_valid;
  logic                out_stall;
  logic [NODE_W-1:0]   out_ancestor;

  tree_lowest_common_ancestor_unit dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action),
    .in_first_node(in_first_node), .in_second_node(in_second_node),
    .out_valid(out_valid), .out_stall(out_stall), .out_ancestor(out_ancestor)
  );

  // predictor state
  bit                lift_ok [LEVELS][MAX_NODES];
  bit [NODE_W-1:0]   lift_to [LEVELS][MAX_NODES];
  int unsigned       node_depth [MAX_NODES];
  bit [COUNT_W-1:0]  node_count_reg;

  logic [NODE_W-1:0] ancestor_q[$];
  int                error_count;
  int                items_sent;
  int                queries_checked;
  int                builds_done;
  int                sessions_done;
  int                idle_cycles;
  bit                calm;

  typedef struct {
    tlca_pkg::action_t act;
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;
    bit                typed;
    logic [NODE_W-1:0] ans;
  } step_row_t;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic int unsigned live_count();
    int unsigned n;
    n = node_count_reg;
    if (n == 0) n = 1;
    if (n > MAX_NODES) n = MAX_NODES;
    return n;
  endfunction

  function automatic void wipe_tree();
    for (int k = 0; k < LEVELS; k++)
      for (int j = 0; j < MAX_NODES; j++) begin
        lift_ok[k][j] = 1'b0;
        lift_to[k][j] = '0;
      end
    for (int j = 0; j < MAX_NODES; j++) node_depth[j] = 0;
  endfunction

  function automatic void build_lifting();
    int unsigned u, d, p;
    for (int k = 1; k < LEVELS; k++)
      for (int j = 0; j < MAX_NODES; j++) begin
        lift_ok[k][j] = 1'b0;
        lift_to[k][j] = '0;
        if (lift_ok[k-1][j]) begin
          p = lift_to[k-1][j];
          if (lift_ok[k-1][p]) begin
            lift_ok[k][j] = 1'b1;
            lift_to[k][j] = lift_to[k-1][p];
          end
        end
      end
    for (int j = 0; j < MAX_NODES; j++) begin
      u = j;
      d = 0;
      for (int k = LEVELS - 1; k >= 0; k--)
        if (lift_ok[k][u]) begin
          d += 1 << k;
          u = lift_to[k][u];
        end
      node_depth[j] = d;
    end
  endfunction

  function automatic logic [NODE_W-1:0] common_ancestor(input int unsigned a,
                                                        input int unsigned b);
    int unsigned u, v, t, diff;
    u = a;
    v = b;
    if (node_depth[u] > node_depth[v]) begin
      t = u; u = v; v = t;
    end
    diff = node_depth[v] - node_depth[u];
    for (int k = LEVELS - 1; k >= 0; k--)
      if (diff[k] && lift_ok[k][v]) v = lift_to[k][v];
    if (u == v) return NODE_W'(u);
    for (int k = LEVELS - 1; k >= 0; k--)
      if (lift_ok[k][u] && !(lift_ok[k][v] && lift_to[k][v] == lift_to[k][u])) begin
        u = lift_to[k][u];
        v = lift_to[k][v];
      end
    if (!lift_ok[0][u]) return tlca_pkg::NO_ANCESTOR;
    return lift_to[0][u];
  endfunction

  // Apply an accepted item to the predictor; returns 1 when an ancestor is due.
  function automatic bit predict_item(input tlca_pkg::action_t act, input int unsigned a,
                                      input int unsigned b,
                                      output logic [NODE_W-1:0] ans);
    int unsigned n;
    n = live_count();
    ans = '0;
    case (act)
      tlca_pkg::ACT_CLEAR: wipe_tree();
      tlca_pkg::ACT_SET: begin
        if (a < n && b < n) begin
          lift_ok[0][a] = 1'b1;
          lift_to[0][a] = NODE_W'(b);
        end
      end
      tlca_pkg::ACT_BUILD: begin
        build_lifting();
        builds_done++;
      end
      default: begin
        if (a < n && b < n) begin
          ans = common_ancestor(a, b);
          return 1'b1;
        end
      end
    endcase
    return 1'b0;
  endfunction

  task automatic send_item(input tlca_pkg::action_t act, input logic [NODE_W-1:0] a,
                           input logic [NODE_W-1:0] b, input bit typed,
                           input logic [NODE_W-1:0] typed_ans);
    logic [NODE_W-1:0] ans;
    if (!calm && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= act;
    in_first_node  <= a;
    in_second_node <= b;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (predict_item(act, a, b, ans))
      ancestor_q = {ancestor_q, (typed ? typed_ans : ans)};
  endtask

  // Hold until every ancestor has come and the unit has gone quiet.
  task automatic wait_quiet();
    int quiet;
    in_valid <= 1'b0;
    while (ancestor_q.size() != 0) @(posedge clk);
    quiet = 0;
    while (quiet < 8) begin
      @(posedge clk);
      quiet = in_stall ? 0 : quiet + 1;
    end
    repeat (100) @(posedge clk);
  endtask

  task automatic write_count(input logic [COUNT_W-1:0] value);
    wait_quiet();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    node_count_reg = value;
  endtask

  function automatic logic [NODE_W-1:0] pick_node(input int unsigned n);
    if ($urandom_range(99) < 8) return NODE_W'($urandom());
    return NODE_W'($urandom_range(n - 1));
  endfunction

  task automatic run_session(input logic [COUNT_W-1:0] count, input bit long_chain);
    int unsigned n, links, queries;
    logic [NODE_W-1:0] child, parent;
    write_count(count);
    n = live_count();
    send_item(tlca_pkg::ACT_CLEAR, NODE_W'($urandom()), NODE_W'($urandom()), 1'b0, '0);
    if (long_chain) begin
      // chain through every node, closed into a loop: depths saturate
      for (int i = 1; i < n; i++) send_item(tlca_pkg::ACT_SET, NODE_W'(i), NODE_W'(i - 1),
                                            1'b0, '0);
      send_item(tlca_pkg::ACT_SET, NODE_W'(0), NODE_W'(n - 1), 1'b0, '0);
    end else begin
      links = (n < 40) ? n : 40;
      for (int i = 0; i < links; i++) begin
        child = (n <= 40) ? NODE_W'(i) : NODE_W'($urandom_range(n - 1));
        if (child != 0 && $urandom_range(99) < 75)
          parent = NODE_W'($urandom_range(child - 1));
        else
          parent = pick_node(n);
        if (child == 0 && $urandom_range(99) < 70) continue;
        if ($urandom_range(99) < 6) child = NODE_W'($urandom());
        send_item(tlca_pkg::ACT_SET, child, parent, 1'b0, '0);
      end
    end
    // a few queries on stale tables before the build
    if ($urandom_range(99) < 30)
      repeat (3) send_item(tlca_pkg::ACT_QUERY, pick_node(n), pick_node(n), 1'b0, '0);
    send_item(tlca_pkg::ACT_BUILD, NODE_W'($urandom()), NODE_W'($urandom()), 1'b0, '0);
    queries = $urandom_range(30, 60);
    for (int i = 0; i < queries; i++) begin
      if (i == queries / 2 && sessions_done == 2) wait_quiet();
      send_item(tlca_pkg::ACT_QUERY, pick_node(n), pick_node(n), 1'b0, '0);
    end
    // stray links after the build: only level zero changes, so higher levels and depths go stale
    if ($urandom_range(99) < 40) begin
      send_item(tlca_pkg::ACT_SET, pick_node(n), pick_node(n), 1'b0, '0);
      repeat (4) send_item(tlca_pkg::ACT_QUERY, pick_node(n), pick_node(n), 1'b0, '0);
    end
    sessions_done++;
  endtask

  step_row_t directed[$];

  initial begin
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    in_valid       = 1'b0;
    in_action      = tlca_pkg::ACT_CLEAR;
    in_first_node  = '0;
    in_second_node = '0;
    rst_n          = 1'b0;
    calm           = 1'b0;
    node_count_reg = 1;
    wipe_tree();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // 0 <- 1 <- 2 <- 1023 <- 5, with 3 and 4 left as lone roots
    directed = '{
      '{tlca_pkg::ACT_CLEAR, 10'd0,    10'd0,    1'b0, 10'd0},
      '{tlca_pkg::ACT_SET,   10'd1,    10'd0,    1'b0, 10'd0},
      '{tlca_pkg::ACT_SET,   10'd2,    10'd1,    1'b0, 10'd0},
      '{tlca_pkg::ACT_SET,   10'd1023, 10'd2,    1'b0, 10'd0},
      '{tlca_pkg::ACT_SET,   10'd5,    10'd1023, 1'b0, 10'd0},
      '{tlca_pkg::ACT_BUILD, 10'd0,    10'd0,    1'b0, 10'd0},
      '{tlca_pkg::ACT_QUERY, 10'd0,    10'd0,    1'b1, 10'd0},
      '{tlca_pkg::ACT_QUERY, 10'd1023, 10'd2,    1'b1, 10'd2},
      '{tlca_pkg::ACT_QUERY, 10'd1023, 10'd1,    1'b1, 10'd1},
      '{tlca_pkg::ACT_QUERY, 10'd5,    10'd1023, 1'b1, 10'd1023},
      '{tlca_pkg::ACT_QUERY, 10'd1023, 10'd0,    1'b1, 10'd0},
      '{tlca_pkg::ACT_QUERY, 10'd3,    10'd4,    1'b1, tlca_pkg::NO_ANCESTOR},
      '{tlca_pkg::ACT_QUERY, 10'd5,    10'd4,    1'b1, tlca_pkg::NO_ANCESTOR},
      '{tlca_pkg::ACT_QUERY, 10'd5,    10'd2,    1'b0, 10'd0},
      '{tlca_pkg::ACT_SET,   10'd3,    10'd5,    1'b0, 10'd0},
      '{tlca_pkg::ACT_SET,   10'd4,    10'd5,    1'b0, 10'd0},
      '{tlca_pkg::ACT_SET,   10'd3,    10'd1,    1'b0, 10'd0},
      '{tlca_pkg::ACT_BUILD, 10'd1023, 10'd1023, 1'b0, 10'd0},
      '{tlca_pkg::ACT_QUERY, 10'd3,    10'd4,    1'b0, 10'd0},
      '{tlca_pkg::ACT_QUERY, 10'd4,    10'd3,    1'b0, 10'd0},
      '{tlca_pkg::ACT_QUERY, 10'd1022, 10'd1023, 1'b1, tlca_pkg::NO_ANCESTOR}
    };
    write_count(11'd1024);
    foreach (directed[i])
      send_item(directed[i].act, directed[i].a, directed[i].b,
                directed[i].typed, directed[i].ans);

    run_session(11'd512, 1'b1);
    calm = 1'b1;
    run_session(11'd2, 1'b0);
    calm = 1'b0;
    run_session(11'd0, 1'b0);
    run_session(11'd2047, 1'b0);
    run_session(11'd1, 1'b0);
    run_session(11'd1500, 1'b0);
    while (items_sent < 1200)
      run_session(($urandom_range(99) < 15) ? 11'd1024 : COUNT_W'($urandom_range(2, 64)),
                  1'b0);

    wait_quiet();
    $display("covered %0d items in %0d tree sessions, %0d builds, %0d ancestors checked",
             items_sent, sessions_done, builds_done, queries_checked);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // result side: random stall, with a calm stretch
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 38);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (ancestor_q.size() == 0) begin
        report_mismatch($sformatf("ancestor %0d with none expected", out_ancestor));
      end else begin
        if (out_ancestor !== ancestor_q[0])
          report_mismatch($sformatf("ancestor %0d, expected %0d",
                                    out_ancestor, ancestor_q[0]));
        void'(ancestor_q.pop_front());
        queries_checked++;
      end
    end
  end

  // watchdog: cycles with nothing accepted on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

endmodule
